/* sv/lqs_pkg.sv */
`timescale 1ns / 1ps

package lqs_pkg;

  // data width of one stored entry
  localparam int unsigned DataW = 32;

  // operation codes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_SEARCH = 2'd2;
  localparam logic [1:0] FUNC_NOP    = 2'd3;

  // status codes
  localparam logic [1:0] STAT_DONE     = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_EMPTY    = 2'd2;
  localparam logic [1:0] STAT_NOTFOUND = 2'd3;

  // input item
  typedef struct packed {
    logic [1:0]        func;
    logic signed [31:0] value;
  } in_t;

  // result item
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [2:0]         found_slot;
  } out_t;

endpackage

/* sv/lqs_ram.sv */
`timescale 1ns / 1ps

module lqs_ram #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [lqs_pkg::DataW-1:0]  wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [lqs_pkg::DataW-1:0]  rdata_o
);

  logic [lqs_pkg::DataW-1:0] mem [DEPTH];
  logic [lqs_pkg::DataW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/linear_queue_with_search_top.sv */
// insert, no-op and rejected operations give their result in the cycle after the transfer
// delete reads the head slot, then returns it; search reads from the head to a match or the end
// one item at a time; scan reads one slot per cycle from the single read port if output is free
// a waiting result does not block acceptance unless the output register cannot drain
// reset: head and fill pointers clear to zero (empty); slot storage is not cleared
`timescale 1ns / 1ps

module linear_queue_with_search_top #(
  parameter int unsigned DEPTH = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  lqs_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output lqs_pkg::out_t out_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned FW = AW + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DEL,
    ST_SRCH
  } state_e;

  state_e               state_q, state_d;
  logic [AW-1:0]        head_q, head_d;
  logic [FW-1:0]        fill_q, fill_d;
  logic [AW-1:0]        idx_q, idx_d;
  logic signed [31:0]   key_q, key_d;
  logic                 out_valid_q;
  lqs_pkg::out_t        out_q;

  logic                 out_free;
  logic                 accept;
  logic                 is_empty;
  logic                 is_full;
  logic                 res_valid;
  lqs_pkg::out_t        res;
  logic                 ram_we;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [lqs_pkg::DataW-1:0] ram_rdata;
  logic [FW-1:0]        idx_next;
  logic [FW-1:0]        head_next;
  logic [AW+2:0]        slot_ext;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_empty   = ({1'b0, head_q} >= fill_q);
  assign is_full    = (fill_q >= FW'(DEPTH));
  assign idx_next   = {1'b0, idx_q} + FW'(1);
  assign head_next  = {1'b0, head_q} + FW'(1);
  assign slot_ext   = {3'b000, idx_q};

  // slot storage
  lqs_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (in_data_i.value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // operation sequencing
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    fill_d    = fill_q;
    idx_d     = idx_q;
    key_d     = key_q;
    res_valid = 1'b0;
    res       = '0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = head_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data_i.func)
            lqs_pkg::FUNC_INSERT: begin
              res_valid = 1'b1;
              if (is_full) begin
                res.status = lqs_pkg::STAT_FULL;
              end else begin
                ram_we = 1'b1;
                fill_d = fill_q + FW'(1);
              end
            end
            lqs_pkg::FUNC_DELETE: begin
              if (is_empty) begin
                res_valid  = 1'b1;
                res.status = lqs_pkg::STAT_EMPTY;
              end else begin
                ram_re  = 1'b1;
                idx_d   = head_q;
                state_d = ST_DEL;
              end
            end
            lqs_pkg::FUNC_SEARCH: begin
              if (is_empty) begin
                res_valid  = 1'b1;
                res.status = lqs_pkg::STAT_NOTFOUND;
              end else begin
                ram_re  = 1'b1;
                idx_d   = head_q;
                key_d   = in_data_i.value;
                state_d = ST_SRCH;
              end
            end
            lqs_pkg::FUNC_NOP: begin
              res_valid = 1'b1;
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      ST_DEL: begin
        if (out_free) begin
          res_valid         = 1'b1;
          res.removed_value = ram_rdata;
          state_d           = ST_IDLE;
          if (head_next == fill_q) begin
            head_d = '0;
            fill_d = '0;
          end else begin
            head_d = head_q + AW'(1);
          end
        end
      end
      ST_SRCH: begin
        if (out_free) begin
          priority if (ram_rdata == key_q) begin
            res_valid      = 1'b1;
            res.found_slot = slot_ext[2:0];
            state_d        = ST_IDLE;
          end else if (idx_next >= fill_q) begin
            res_valid  = 1'b1;
            res.status = lqs_pkg::STAT_NOTFOUND;
            state_d    = ST_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_next[AW-1:0];
            idx_d     = idx_next[AW-1:0];
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      fill_q  <= fill_d;
      if (out_free) begin
        out_valid_q <= res_valid;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    key_q <= key_d;
    if (out_free && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // fill pointer never passes the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= FW'(DEPTH))
    else $error("fill pointer beyond depth");

  // an empty queue has its head at slot zero, otherwise the head is below the fill pointer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0) ? (head_q == '0) : ({1'b0, head_q} < fill_q))
    else $error("head and fill pointers inconsistent");

  // no transfer is taken while an operation is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o)
    else $error("input taken while busy");

  // an insert into a queue with room grows the fill pointer by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.func == lqs_pkg::FUNC_INSERT && !is_full)
      |=> (fill_q == $past(fill_q) + FW'(1)))
    else $error("insert did not advance fill pointer");

  // a read is followed in the next cycle by the delete or search state that takes its data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> (state_q == ST_DEL || state_q == ST_SRCH))
    else $error("read issued outside an operation");

endmodule

/* sim/tb_linear_queue_with_search_top.sv */
`timescale 1ns / 1ps

module tb_linear_queue_with_search_top;

  localparam int unsigned DEPTH      = 8;
  localparam int          RAND_ITEMS = 1400;
  localparam int          HOLD_CYC   = 80;
  localparam int          DRAIN_CYC  = 24;
  localparam int          CYC_LIMIT  = 300000;

  // one row of the directed table
  typedef struct {
    lqs_pkg::in_t  item;
    bit            typed;
    lqs_pkg::out_t want;
  } dir_row_t;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  lqs_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  lqs_pkg::out_t out_data;

  // shadow of the queue contents
  logic signed [31:0] slot_mem [DEPTH];
  logic [2:0]         head_ptr;
  logic [3:0]         fill_ptr;

  lqs_pkg::out_t      due_q [$];
  dir_row_t           dir_rows [$];
  logic signed [31:0] recent_vals [$];

  int tx_pct      = 16;
  int rx_pct      = 72;
  int hold_reqs   = 0;
  int hold_served = 0;
  int hold_left   = 0;
  int mismatch_cnt = 0;
  int cycle_cnt   = 0;

  linear_queue_with_search_top #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // expected result of one operation, updates the shadow queue
  function automatic lqs_pkg::out_t queue_op_model(input lqs_pkg::in_t it);
    lqs_pkg::out_t res;
    bit            hit;
    res = '0;
    hit = 1'b0;
    case (it.func)
      lqs_pkg::FUNC_INSERT: begin
        if (fill_ptr >= DEPTH) begin
          res.status = lqs_pkg::STAT_FULL;
        end else begin
          slot_mem[fill_ptr[2:0]] = it.value;
          fill_ptr = fill_ptr + 4'd1;
          res.status = lqs_pkg::STAT_DONE;
        end
      end
      lqs_pkg::FUNC_DELETE: begin
        if (fill_ptr == 4'd0 || {1'b0, head_ptr} >= fill_ptr) begin
          res.status = lqs_pkg::STAT_EMPTY;
        end else begin
          res.status = lqs_pkg::STAT_DONE;
          res.removed_value = slot_mem[head_ptr];
          if ({1'b0, head_ptr} + 4'd1 == fill_ptr) begin
            head_ptr = '0;
            fill_ptr = '0;
          end else begin
            head_ptr = head_ptr + 3'd1;
          end
        end
      end
      lqs_pkg::FUNC_SEARCH: begin
        // first match scanning from the head
        for (int i = head_ptr; i < fill_ptr; i++) begin
          if (!hit && slot_mem[i] == it.value) begin
            hit = 1'b1;
            res.found_slot = i[2:0];
          end
        end
        res.status = hit ? lqs_pkg::STAT_DONE : lqs_pkg::STAT_NOTFOUND;
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  task automatic add_row(input logic [1:0] f, input logic [31:0] v, input bit typed,
                         input logic [1:0] st, input logic [31:0] rm, input logic [2:0] sl);
    dir_row_t row;
    row.item.func          = f;
    row.item.value         = v;
    row.typed              = typed;
    row.want.status        = st;
    row.want.removed_value = rm;
    row.want.found_slot    = sl;
    dir_rows.push_back(row);
  endtask

  // offer one item, record its expected result at the transfer
  task automatic send_item(input lqs_pkg::in_t it, input bit typed, input lqs_pkg::out_t want);
    lqs_pkg::out_t pred;
    while ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    pred = queue_op_model(it);
    due_q.push_back(typed ? want : pred);
  endtask

  task automatic wait_drained();
    while (due_q.size() != 0) @(posedge clk);
  endtask

  // receiver stall, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_served) begin
      out_stall   <= 1'b1;
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_CYC;
    end else begin
      out_stall <= ($urandom_range(99) < rx_pct);
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin : result_check
    lqs_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("result with nothing expected: status %0d removed %0d slot %0d",
                   out_data.status, out_data.removed_value, out_data.found_slot);
      end else begin
        want = due_q.pop_front();
        if (out_data.status !== want.status ||
            out_data.removed_value !== want.removed_value ||
            out_data.found_slot !== want.found_slot) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected status %0d removed %0d slot %0d, got %0d %0d %0d",
                     want.status, want.removed_value, want.found_slot,
                     out_data.status, out_data.removed_value, out_data.found_slot);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYC_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    lqs_pkg::in_t       it;
    logic [1:0]         f;
    logic signed [31:0] v;
    int                 r;
    bit                 filling;
    int                 run_left;

    filling  = 1'b0;
    run_left = 0;
    head_ptr = '0;
    fill_ptr = '0;
    for (int i = 0; i < DEPTH; i++) slot_mem[i] = '0;

    // directed table: empty cases, extremes, fill to full, drain to empty
    add_row(lqs_pkg::FUNC_DELETE, 32'h0000_0000, 1'b1, lqs_pkg::STAT_EMPTY,    '0, '0);
    add_row(lqs_pkg::FUNC_SEARCH, 32'h0000_0000, 1'b1, lqs_pkg::STAT_NOTFOUND, '0, '0);
    add_row(lqs_pkg::FUNC_NOP,    32'hFFFF_FFFF, 1'b1, lqs_pkg::STAT_DONE,     '0, '0);
    add_row(lqs_pkg::FUNC_INSERT, 32'h8000_0000, 1'b1, lqs_pkg::STAT_DONE,     '0, '0);
    add_row(lqs_pkg::FUNC_INSERT, 32'h7FFF_FFFF, 1'b1, lqs_pkg::STAT_DONE,     '0, '0);
    add_row(lqs_pkg::FUNC_INSERT, 32'h0000_0000, 1'b1, lqs_pkg::STAT_DONE,     '0, '0);
    add_row(lqs_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 1'b1, lqs_pkg::STAT_DONE,     '0, '0);
    add_row(lqs_pkg::FUNC_SEARCH, 32'h7FFF_FFFF, 1'b0, '0, '0, '0);
    add_row(lqs_pkg::FUNC_SEARCH, 32'h0000_0005, 1'b0, '0, '0, '0);
    add_row(lqs_pkg::FUNC_INSERT, 32'h0000_0005, 1'b1, lqs_pkg::STAT_DONE,     '0, '0);
    add_row(lqs_pkg::FUNC_INSERT, 32'h0000_0005, 1'b1, lqs_pkg::STAT_DONE,     '0, '0);
    add_row(lqs_pkg::FUNC_INSERT, 32'h1234_5678, 1'b1, lqs_pkg::STAT_DONE,     '0, '0);
    add_row(lqs_pkg::FUNC_INSERT, 32'hA5A5_A5A5, 1'b1, lqs_pkg::STAT_DONE,     '0, '0);
    add_row(lqs_pkg::FUNC_INSERT, 32'h0000_0001, 1'b1, lqs_pkg::STAT_FULL,     '0, '0);
    add_row(lqs_pkg::FUNC_SEARCH, 32'h0000_0005, 1'b0, '0, '0, '0);
    add_row(lqs_pkg::FUNC_DELETE, 32'h0000_0000, 1'b0, '0, '0, '0);
    add_row(lqs_pkg::FUNC_DELETE, 32'h0000_0000, 1'b0, '0, '0, '0);
    // head has moved but the tail is still at the end
    add_row(lqs_pkg::FUNC_INSERT, 32'h0000_0009, 1'b1, lqs_pkg::STAT_FULL,     '0, '0);
    add_row(lqs_pkg::FUNC_SEARCH, 32'hA5A5_A5A5, 1'b0, '0, '0, '0);
    for (int i = 0; i < 6; i++)
      add_row(lqs_pkg::FUNC_DELETE, 32'h0000_0000, 1'b0, '0, '0, '0);
    add_row(lqs_pkg::FUNC_DELETE, 32'h0000_0000, 1'b1, lqs_pkg::STAT_EMPTY,    '0, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    in_valid <= 1'b0;
    wait_drained();

    // random phases: busy receiver, busy sender, no idling but one long receiver hold-off
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 0) begin
        tx_pct = 16;
        rx_pct <= 72;
      end else if (ph == 1) begin
        tx_pct = 72;
        rx_pct <= 16;
      end else begin
        tx_pct = 0;
        rx_pct <= 0;
        hold_reqs <= hold_reqs + 1;
      end
      for (int n = 0; n < RAND_ITEMS / 3; n++) begin
        // alternate fill-heavy and drain-heavy runs
        if (run_left == 0) begin
          filling  = ~filling;
          run_left = $urandom_range(14, 6);
        end
        run_left--;
        r = $urandom_range(99);
        if (filling)
          f = (r < 60) ? lqs_pkg::FUNC_INSERT : (r < 85) ? lqs_pkg::FUNC_SEARCH :
              (r < 95) ? lqs_pkg::FUNC_DELETE : lqs_pkg::FUNC_NOP;
        else
          f = (r < 55) ? lqs_pkg::FUNC_DELETE : (r < 80) ? lqs_pkg::FUNC_SEARCH :
              (r < 95) ? lqs_pkg::FUNC_INSERT : lqs_pkg::FUNC_NOP;
        r = $urandom_range(9);
        if (r == 0) begin
          case ($urandom_range(3))
            0:       v = 32'sh8000_0000;
            1:       v = 32'sh7FFF_FFFF;
            2:       v = 32'sh0000_0000;
            default: v = -32'sd1;
          endcase
        end else if (r <= 3) begin
          v = $urandom_range(7);
        end else begin
          v = $urandom;
        end
        // searches mostly look for something recently stored
        if (f == lqs_pkg::FUNC_SEARCH && recent_vals.size() > 0 && $urandom_range(9) < 6)
          v = recent_vals[$urandom_range(recent_vals.size() - 1)];
        if (f == lqs_pkg::FUNC_INSERT) begin
          recent_vals.push_back(v);
          if (recent_vals.size() > 16) void'(recent_vals.pop_front());
        end
        it.func  = f;
        it.value = v;
        send_item(it, 1'b0, '0);
      end
      in_valid <= 1'b0;
      wait_drained();
    end

    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatch_cnt == 0 && due_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
